FILE: hw/rtl/sdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync deframer package
// Shared widths, constants, the job type passed from the front part to the
// back part, and the PN9 whitening table.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // Fixed field widths.
  localparam int PATTERN_W = 56;
  localparam int IDX_W     = 6;

  // Default geometry.
  localparam int BYTES_PER_FRAME_DEFAULT = 64;
  localparam int SYNC_BITS_DEFAULT       = 56;
  localparam int QUEUE_DEPTH_DEFAULT     = 4;

  // Sync pattern after reset: preamble followed by the sync word.
  localparam logic [PATTERN_W-1:0] SYNC_PATTERN_RESET = 56'hAA_AAAA_C194_C1C6;

  // Byte positions with a special meaning within a frame.
  localparam logic [IDX_W-1:0] PN9_START   = 6'd6;
  localparam logic [IDX_W-1:0] CHK_FIRST   = 6'd8;
  localparam logic [IDX_W-1:0] CHK_XOR_IDX = 6'd61;
  localparam logic [IDX_W-1:0] CHK_SUM_IDX = 6'd62;

  // PN9 whitening sequence, one byte for each frame byte from PN9_START on.
  localparam int PN9_LEN = 58;
  localparam logic [7:0] PN9_TAB [PN9_LEN] = '{
    8'hFF, 8'h87, 8'hB8, 8'h59, 8'hB7, 8'hA1, 8'hCC, 8'h24,
    8'h57, 8'h5E, 8'h4B, 8'h9C, 8'h0E, 8'hE9, 8'hEA, 8'h50,
    8'h2A, 8'hBE, 8'hB4, 8'h1B, 8'hB6, 8'hB0, 8'h5D, 8'hF1,
    8'hE6, 8'h9A, 8'hE3, 8'h45, 8'hFD, 8'h2C, 8'h53, 8'h18,
    8'h0C, 8'hCA, 8'hC9, 8'hFB, 8'h49, 8'h37, 8'hE5, 8'hA8,
    8'h51, 8'h3B, 8'h2F, 8'h61, 8'hAA, 8'h72, 8'h18, 8'h84,
    8'h02, 8'h23, 8'h23, 8'hAB, 8'h63, 8'h89, 8'h51, 8'hB3,
    8'hE7, 8'h8B
  };

  // A job: either a whole header (the matched pattern) or one raw frame byte.
  typedef struct packed {
    logic                 is_header;
    logic [PATTERN_W-1:0] payload;
    logic [IDX_W-1:0]     idx;
  } job_t;

  // Whitening mask for the byte at a given frame position.
  function automatic logic [7:0] pn9_mask(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] pos;
    pos = idx - PN9_START;
    if (idx >= PN9_START) begin
      return PN9_TAB[pos];
    end
    return 8'h00;
  endfunction

endpackage

FILE: hw/rtl/sdf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync deframer front part
// Keeps the symbol window, hunts for the sync pattern and collects frame
// bits into bytes. Each accepted symbol yields at most one job.
// ----------------------------------------------------------------------------
module sdf_front #(
  parameter int BYTES_PER_FRAME = sdf_pkg::BYTES_PER_FRAME_DEFAULT,
  parameter int SYNC_BITS       = sdf_pkg::SYNC_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sym_accept,
  input  logic                          data_bit,
  input  logic                          erasure,
  input  logic                          pattern_we,
  input  logic [sdf_pkg::PATTERN_W-1:0] pattern_wdata,
  output logic                          job_valid,
  output sdf_pkg::job_t                 job
);
  import sdf_pkg::*;

  localparam int RUN_W = $clog2(SYNC_BITS + 1);
  localparam int FBC_W = $clog2(BYTES_PER_FRAME * 8 + 1);
  localparam int REM_BITS = SYNC_BITS % 8;
  localparam logic [7:0] REM_MASK = 8'((1 << REM_BITS) - 1);

  logic [SYNC_BITS-1:0] pattern;
  logic [SYNC_BITS-1:0] window_bits;
  logic [RUN_W-1:0]     valid_run;
  logic                 in_frame;
  logic [FBC_W-1:0]     frame_bit_count;
  logic [7:0]           byte_shift;

  logic [SYNC_BITS-1:0] window_next;
  logic [RUN_W-1:0]     run_next;
  logic                 sync_hit;
  logic [FBC_W-1:0]     count_next;
  logic [7:0]           shift_next;
  logic                 byte_done;
  logic [IDX_W-1:0]     byte_idx;
  logic                 frame_end;

  // Window, run length and byte assembly for the symbol on the inputs.
  always_comb begin
    window_next = {window_bits[SYNC_BITS-2:0], data_bit};
    run_next    = (valid_run == RUN_W'(SYNC_BITS)) ? valid_run : valid_run + 1'b1;
    sync_hit    = !in_frame && (run_next == RUN_W'(SYNC_BITS)) && (window_next == pattern);
    count_next  = frame_bit_count + 1'b1;
    shift_next  = {byte_shift[6:0], data_bit};
    byte_done   = in_frame && (count_next[2:0] == 3'd0);
    byte_idx    = IDX_W'(count_next[FBC_W-1:3] - 1'b1);
    frame_end   = byte_done && (byte_idx == IDX_W'(BYTES_PER_FRAME - 1));
  end

  // Job for the back part.
  always_comb begin
    job_valid     = sym_accept && !erasure && (sync_hit || byte_done);
    job.is_header = sync_hit;
    job.payload   = sync_hit ? PATTERN_W'(pattern) : PATTERN_W'(shift_next);
    job.idx       = sync_hit ? '0 : byte_idx;
  end

  // Sync pattern register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= SYNC_PATTERN_RESET[SYNC_BITS-1:0];
    end else if (pattern_we) begin
      pattern <= pattern_wdata[SYNC_BITS-1:0];
    end
  end

  // Hunting and frame collection state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits     <= '0;
      valid_run       <= '0;
      in_frame        <= 1'b0;
      frame_bit_count <= '0;
      byte_shift      <= '0;
    end else if (sym_accept) begin
      if (erasure) begin
        window_bits <= {window_bits[SYNC_BITS-2:0], 1'b0};
        valid_run   <= '0;
      end else begin
        window_bits <= window_next;
        valid_run   <= run_next;
        if (sync_hit) begin
          in_frame        <= 1'b1;
          frame_bit_count <= FBC_W'(SYNC_BITS);
          byte_shift      <= pattern[7:0] & REM_MASK;
        end else if (in_frame) begin
          if (frame_end) begin
            in_frame        <= 1'b0;
            frame_bit_count <= '0;
            byte_shift      <= '0;
          end else begin
            frame_bit_count <= count_next;
            byte_shift      <= byte_done ? 8'h00 : shift_next;
          end
        end
      end
    end
  end

endmodule

FILE: hw/rtl/sdf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync deframer job queue
// Small register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module sdf_queue #(
  parameter int DEPTH = sdf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sdf_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output sdf_pkg::job_t rd_job
);
  import sdf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_job   = slots[rd_ptr];

  // Storage is written only at the write pointer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/sdf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync deframer back part
// Expands header jobs into header bytes, dewhitens, runs the XOR and sum
// check and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module sdf_back #(
  parameter int BYTES_PER_FRAME = sdf_pkg::BYTES_PER_FRAME_DEFAULT,
  parameter int SYNC_BITS       = sdf_pkg::SYNC_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  sdf_pkg::job_t             job,
  output logic                      job_take,
  input  logic                      pop,
  output logic                      empty,
  output logic [7:0]                frame_byte,
  output logic [sdf_pkg::IDX_W-1:0] byte_index,
  output logic                      last,
  output logic                      check_ok
);
  import sdf_pkg::*;

  localparam int HDR_BYTES = SYNC_BITS / 8;

  logic                 out_valid;
  logic                 hdr_busy;
  logic [SYNC_BITS-1:0] hdr_shift;
  logic [IDX_W-1:0]     hdr_idx;
  logic [7:0]           xor_acc;
  logic [7:0]           sum_acc;
  logic                 xor_match;
  logic                 sum_match;

  logic                 go;
  logic                 hdr_start;
  logic [SYNC_BITS-1:0] pat;
  logic [7:0]           raw;
  logic [IDX_W-1:0]     idx;
  logic [7:0]           b;
  logic                 xor_match_now;
  logic                 sum_match_now;
  logic                 last_now;
  logic                 in_check;

  assign empty = !out_valid;

  // Select the byte that goes out next and work out its check flags.
  always_comb begin
    go        = (!out_valid || pop) && (hdr_busy || job_valid);
    hdr_start = go && !hdr_busy && job.is_header;
    job_take  = go && !hdr_busy;
    pat       = job.payload[SYNC_BITS-1:0];
    if (hdr_busy) begin
      raw = hdr_shift[SYNC_BITS-1 -: 8];
      idx = hdr_idx;
    end else if (job.is_header) begin
      raw = pat[SYNC_BITS-1 -: 8];
      idx = '0;
    end else begin
      raw = job.payload[7:0];
      idx = job.idx;
    end
    b             = raw ^ pn9_mask(idx);
    in_check      = (idx >= CHK_FIRST) && (idx < CHK_XOR_IDX);
    xor_match_now = (idx == CHK_XOR_IDX) ? (b == xor_acc) : xor_match;
    sum_match_now = (idx == CHK_SUM_IDX) ? (b == sum_acc) : sum_match;
    last_now      = (idx == IDX_W'(BYTES_PER_FRAME - 1));
  end

  // Header expansion, check accumulators and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_busy  <= 1'b0;
      xor_acc   <= '0;
      sum_acc   <= '0;
      xor_match <= 1'b0;
      sum_match <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (hdr_start) begin
        // A new frame starts: clear the check state.
        xor_acc   <= '0;
        sum_acc   <= '0;
        xor_match <= 1'b0;
        sum_match <= 1'b0;
        if (HDR_BYTES > 1) begin
          hdr_busy  <= 1'b1;
          hdr_shift <= pat << 8;
          hdr_idx   <= IDX_W'(1);
        end
      end else if (go) begin
        if (hdr_busy) begin
          hdr_shift <= hdr_shift << 8;
          hdr_idx   <= hdr_idx + 1'b1;
          if (hdr_idx == IDX_W'(HDR_BYTES - 1)) begin
            hdr_busy <= 1'b0;
          end
        end
        if (in_check) begin
          xor_acc <= xor_acc ^ b;
          sum_acc <= sum_acc + b;
        end
        xor_match <= xor_match_now;
        sum_match <= sum_match_now;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (go) begin
      frame_byte <= b;
      byte_index <= idx;
      last       <= last_now;
      check_ok   <= last_now && xor_match_now && sum_match_now;
    end
  end

endmodule

FILE: hw/rtl/sync_deframer_pn9_dewhiten_check_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync deframer with PN9 dewhitening and frame check
// Hunts for a sync pattern in a demodulated bit stream, then delivers the
// header and the dewhitened frame bytes with a check flag on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Symbols enter through a queue-like port: data_bit and erasure are taken
//   when push is high and full is low, one symbol per cycle at most.
//   Results leave through a queue-like port: while empty is low the oldest
//   frame byte, its byte_index, last and check_ok are on the ports, and the
//   transaction completes when pop is high.
//   The sync pattern is written through sync_pattern_we and sync_pattern.
// Flow:
//   A byte reaches the result ports through the job queue and the output
//   register of the back part, when nothing waits ahead of it. A sync match
//   yields SYNC_BITS/8 header bytes, delivered one per cycle by the back
//   part while the receiver keeps taking them; that expansion sets the burst rate.
//   The input side sustains one symbol per cycle; full rises only when the
//   job queue between front and back parts fills, which happens only while
//   the receiver stalls.
// Reset:
//   rst clears the window, returns to hunting, empties the queue and the
//   output register, and restores the default sync pattern. When the
//   receiver stalls, the waiting result holds and jobs build up in the queue.
// ----------------------------------------------------------------------------
module sync_deframer_pn9_dewhiten_check_core #(
  parameter int BYTES_PER_FRAME = sdf_pkg::BYTES_PER_FRAME_DEFAULT,
  parameter int SYNC_BITS       = sdf_pkg::SYNC_BITS_DEFAULT,
  parameter int QUEUE_DEPTH     = sdf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          data_bit,
  input  logic                          erasure,
  input  logic                          sync_pattern_we,
  input  logic [sdf_pkg::PATTERN_W-1:0] sync_pattern,
  input  logic                          pop,
  output logic                          empty,
  output logic [7:0]                    frame_byte,
  output logic [sdf_pkg::IDX_W-1:0]     byte_index,
  output logic                          last,
  output logic                          check_ok
);
  import sdf_pkg::*;

  logic sym_accept;
  logic fr_job_valid;
  job_t fr_job;
  logic q_valid;
  job_t q_job;
  logic q_take;

  // A symbol transaction completes when the queue has room.
  assign sym_accept = push && !full;

  sdf_front #(
    .BYTES_PER_FRAME(BYTES_PER_FRAME),
    .SYNC_BITS      (SYNC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sym_accept   (sym_accept),
    .data_bit     (data_bit),
    .erasure      (erasure),
    .pattern_we   (sync_pattern_we),
    .pattern_wdata(sync_pattern),
    .job_valid    (fr_job_valid),
    .job          (fr_job)
  );

  sdf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fr_job_valid),
    .wr_job  (fr_job),
    .full    (full),
    .rd_en   (q_take),
    .rd_valid(q_valid),
    .rd_job  (q_job)
  );

  sdf_back #(
    .BYTES_PER_FRAME(BYTES_PER_FRAME),
    .SYNC_BITS      (SYNC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_take  (q_take),
    .pop       (pop),
    .empty     (empty),
    .frame_byte(frame_byte),
    .byte_index(byte_index),
    .last      (last),
    .check_ok  (check_ok)
  );

endmodule

FILE: hw/rtl/sdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync deframer port checker
// Properties on the top level ports, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sdf_checker #(
  parameter int BYTES_PER_FRAME = sdf_pkg::BYTES_PER_FRAME_DEFAULT
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      full,
  input logic                      pop,
  input logic                      empty,
  input logic [7:0]                frame_byte,
  input logic [sdf_pkg::IDX_W-1:0] byte_index,
  input logic                      last,
  input logic                      check_ok
);
  import sdf_pkg::*;

  // The last flag is only ever shown on the final byte position.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (byte_index == IDX_W'(BYTES_PER_FRAME - 1)))
    else $error("last flag on a byte other than the final one");

  // A passed check is only reported together with the last byte.
  a_check_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && check_ok) |-> last)
    else $error("check_ok raised on a non-final byte");

  // Reset leaves no result waiting and the input side open.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("result or full flag present after reset");

  // A result that is not taken stays on the ports unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_byte) && $stable(byte_index)))
    else $error("waiting result changed before it was taken");

endmodule

bind sync_deframer_pn9_dewhiten_check_core sdf_checker #(
  .BYTES_PER_FRAME(BYTES_PER_FRAME)
) u_sdf_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .frame_byte(frame_byte),
  .byte_index(byte_index),
  .last      (last),
  .check_ok  (check_ok)
);
